// File: hdl/ipv6ehw_pkg.sv
`default_nettype none

package ipv6ehw_pkg;

  // Default width of the byte positions kept by the walker.
  localparam int OFFSET_BITS_DEF = 16;

  // Length of the fixed IPv6 base header and the place of its next-header byte.
  localparam int BASE_HDR_LEN = 40;
  localparam int BASE_NH_POS  = 6;

  // Width of one result offset on the result channel.
  localparam int OUT_OFFSET_W = 16;

  // Next-header codes that the walker recognises.
  localparam logic [7:0] NH_ICMP4   = 8'd1;
  localparam logic [7:0] NH_TCP     = 8'd6;
  localparam logic [7:0] NH_UDP     = 8'd17;
  localparam logic [7:0] NH_ROUTING = 8'd43;
  localparam logic [7:0] NH_FRAG    = 8'd44;
  localparam logic [7:0] NH_ICMP6   = 8'd58;
  localparam logic [7:0] NH_DSTOPT  = 8'd60;

  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_TRUNCATED   = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_t;

  // One packet byte with its framing marks.
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } beat_t;

  // Outcome of one step of the walk.
  typedef struct packed {
    logic                    emit;
    logic [7:0]              protocol;
    logic [OUT_OFFSET_W-1:0] offset;
    status_t                 status;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/ipv6ehw_walk.sv
`default_nettype none

module ipv6ehw_walk
  import ipv6ehw_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire     clk,
  input  wire     rst_n,
  input  wire     beat_valid,
  input  wire     advance,
  input  beat_t   beat,
  output result_t res
);

  localparam int PW = OFFSET_BITS;
  localparam int NW = OFFSET_BITS + 1;
  // The routing length sum needs room for the header start plus 2048.
  localparam int SW = ((OFFSET_BITS > 12) ? OFFSET_BITS : 12) + 1;

  localparam logic [NW-1:0] POS_MAX_N = {1'b0, {PW{1'b1}}};
  localparam logic [SW-1:0] POS_MAX_S = SW'({PW{1'b1}});

  typedef enum logic [1:0] {
    KIND_BASE  = 2'd0,
    KIND_ROUTE = 2'd1,
    KIND_FRAG  = 2'd2
  } kind_t;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] hs_r, hs_nxt;
  logic [NW-1:0] ns_r, ns_nxt;
  logic [7:0]    pend_r, pend_nxt;
  kind_t         kind_r, kind_nxt;
  logic          done_r, done_nxt;

  // State as seen by this byte, after a restart on the first mark.
  logic [PW-1:0] pos_e, hs_e;
  logic [NW-1:0] ns_e;
  logic [7:0]    pend_e;
  kind_t         kind_e;
  logic          done_e;

  logic [PW-1:0] rel;
  logic          capture;
  logic [7:0]    pend_a;
  logic          route_len;
  logic [SW-1:0] ns_sum;
  logic          route_ovf;
  logic [NW-1:0] ns_a;
  logic [NW-1:0] pos_inc;
  logic          hit;
  logic [PW-1:0] hs_chain;
  logic [NW-1:0] ns_chain;
  result_t       res_c;

  always_comb begin
    if (beat.first) begin
      pos_e  = '0;
      hs_e   = '0;
      ns_e   = NW'(BASE_HDR_LEN);
      pend_e = '0;
      kind_e = KIND_BASE;
      done_e = 1'b0;
    end else begin
      pos_e  = pos_r;
      hs_e   = hs_r;
      ns_e   = ns_r;
      pend_e = pend_r;
      kind_e = kind_r;
      done_e = done_r;
    end
  end

  always_comb begin
    rel       = pos_e - hs_e;
    capture   = (kind_e == KIND_BASE) ? (pos_e == PW'(BASE_NH_POS)) : (rel == '0);
    pend_a    = capture ? beat.data : pend_e;
    route_len = (kind_e == KIND_ROUTE) && (rel == PW'(1));
    ns_sum    = SW'(hs_e) + SW'({beat.data, 3'b000}) + SW'(8);
    route_ovf = route_len && (ns_sum > POS_MAX_S);
    ns_a      = route_len ? ns_sum[NW-1:0] : ns_e;
    pos_inc   = NW'(pos_e) + NW'(1);
    hit       = (pos_inc == ns_a);
    hs_chain  = ns_a[PW-1:0];
    ns_chain  = NW'(hs_chain) + NW'(8);

    pos_nxt  = pos_e;
    hs_nxt   = hs_e;
    ns_nxt   = ns_a;
    pend_nxt = pend_a;
    kind_nxt = kind_e;
    done_nxt = done_e;

    res_c.emit     = 1'b0;
    res_c.protocol = pend_a;
    res_c.offset   = '0;
    res_c.status   = ST_FOUND;

    if (!done_e) begin
      if (route_ovf) begin
        res_c.emit   = 1'b1;
        res_c.status = ST_OVERFLOW;
      end else begin
        if (hit) begin
          case (pend_a)
            NH_ICMP4, NH_TCP, NH_UDP, NH_ICMP6: begin
              res_c.emit   = 1'b1;
              res_c.offset = OUT_OFFSET_W'(ns_a);
              res_c.status = ST_FOUND;
            end
            NH_ROUTING, NH_DSTOPT, NH_FRAG: begin
              kind_nxt = (pend_a == NH_FRAG) ? KIND_FRAG : KIND_ROUTE;
              hs_nxt   = hs_chain;
              ns_nxt   = ns_chain;
              if (ns_chain > POS_MAX_N) begin
                res_c.emit   = 1'b1;
                res_c.status = ST_OVERFLOW;
              end
            end
            default: begin
              res_c.emit   = 1'b1;
              res_c.offset = OUT_OFFSET_W'(ns_a);
              res_c.status = ST_UNSUPPORTED;
            end
          endcase
        end
        if (!res_c.emit) begin
          pos_nxt = pos_inc[PW-1:0];
          if (beat.last) begin
            res_c.emit     = 1'b1;
            res_c.protocol = 8'd0;
            res_c.offset   = OUT_OFFSET_W'(pos_inc);
            res_c.status   = ST_TRUNCATED;
          end
        end
      end
      if (res_c.emit) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    res      = res_c;
    res.emit = beat_valid && res_c.emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hs_r   <= '0;
      ns_r   <= NW'(BASE_HDR_LEN);
      pend_r <= '0;
      kind_r <= KIND_BASE;
      done_r <= 1'b0;
    end else if (advance) begin
      pos_r  <= pos_nxt;
      hs_r   <= hs_nxt;
      ns_r   <= ns_nxt;
      pend_r <= pend_nxt;
      kind_r <= kind_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/ipv6_extension_header_walker.sv
// IPv6 extension header walker.
// A packet enters on the in_ channel one byte per beat: in_tuser marks the
// first byte of a packet (the walk restarts there) and in_tlast its final
// byte. The walker follows the next-header chain through routing,
// destination-options and fragment headers and gives at most one result
// beat per packet on the out_ channel: the transport protocol and its byte
// offset, or an unsupported, truncated or offset-overflow status.
// Each byte is taken into an input register, evaluated there by one short
// compare-and-add path against the walk state, and a result is written to
// an output register, from which the result beat is offered on out_. One
// byte can be taken every cycle, except while a second result is held
// back by a stalled receiver.
// While a result waits on a stalled receiver, bytes that give no result
// keep flowing; only a byte that would give a second result is held in the
// input register, and in_tready falls behind it.
// Synchronous reset clears both registers and returns the walk to the start
// of a packet, so bytes after reset are read as a packet at offset zero.
`default_nettype none

module ipv6_extension_header_walker
  import ipv6ehw_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tuser,   // [0] first_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata,  // [7:0] protocol, [23:8] transport_offset
  output logic [1:0]  out_tuser   // [1:0] status
);

  // Input register: one byte beat waiting to be walked.
  logic    s1_valid_r, s1_valid_nxt;
  beat_t   s1_beat_r;
  logic    s1_adv;
  logic    s1_fire;
  result_t res;

  // Output register: the result beat offered downstream.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  // A byte leaves the input register unless it carries a result and the
  // output register is still full and not being drained.
  assign s1_adv    = !res.emit || !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt = in_tready ? in_tvalid : s1_valid_r;

  always_comb begin
    if (s1_fire && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_beat_r.data  <= in_tdata;
      s1_beat_r.first <= in_tuser;
      s1_beat_r.last  <= in_tlast;
    end
    if (s1_fire && res.emit) begin
      out_res_r <= res;
    end
  end

  ipv6ehw_walk #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (s1_valid_r),
    .advance    (s1_fire),
    .beat       (s1_beat_r),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.offset, out_res_r.protocol};
  assign out_tuser  = out_res_r.status;

endmodule

`default_nettype wire
